>>> rtl/fcd_pkg.sv
// ----------------------------------------------------------------------------
// fcd_pkg
// Shared types and constants of the frontier cell detector: configuration
// register indexes, field widths and the cell descriptor passed between the
// position tracker and the judge stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcd_pkg;

  // Fixed field widths
  localparam int PIX_W      = 8;
  localparam int COORD_W    = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Configuration register defaults
  localparam logic [PIX_W-1:0] FREE_RST    = 8'd254;
  localparam logic [PIX_W-1:0] UNKNOWN_RST = 8'd205;
  localparam int               DIM_RST     = 1024;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FREE    = 2'd0,
    CFG_UNKNOWN = 2'd1,
    CFG_WIDTH   = 2'd2,
    CFG_HEIGHT  = 2'd3
  } cfg_idx_e;

  // One line-store word: upper row on top, centre row below
  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] centre;
  } line_word_t;

  // Position of the cell that an item completes, and its border flags
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               vld;     // item completes a cell of the image
    logic               has_up;
    logic               has_dn;
    logic               has_lf;
    logic               has_rt;
    logic               last;    // final cell of the frame
  } cell_t;

endpackage

>>> rtl/fcd_cfg.sv
// ----------------------------------------------------------------------------
// fcd_cfg
// Configuration registers. Image dimensions are clamped to 1..MAX on write;
// a geometry write pulses a restart of the input position counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcd_cfg import fcd_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int WW         = $clog2(MAX_WIDTH + 1),
  parameter int HW         = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic [PIX_W-1:0]      free_o,
  output logic [PIX_W-1:0]      unknown_o,
  output logic [WW-1:0]         width_o,
  output logic [HW-1:0]         height_o,
  output logic                  restart_o
);

  localparam logic [WW-1:0] WIDTH_RST  = WW'((MAX_WIDTH < DIM_RST) ? MAX_WIDTH : DIM_RST);
  localparam logic [HW-1:0] HEIGHT_RST = HW'((MAX_HEIGHT < DIM_RST) ? MAX_HEIGHT : DIM_RST);

  logic [PIX_W-1:0] free_q, free_d;
  logic [PIX_W-1:0] unknown_q, unknown_d;
  logic [WW-1:0]    width_q, width_d, width_clamp;
  logic [HW-1:0]    height_q, height_d, height_clamp;
  logic             wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  // Clamp written dimensions into 1..MAX
  always_comb begin
    if (cfg_data_i == '0) begin
      width_clamp  = WW'(1);
      height_clamp = HW'(1);
    end else begin
      width_clamp  = (32'(cfg_data_i) > MAX_WIDTH)  ? WW'(MAX_WIDTH)  : WW'(cfg_data_i);
      height_clamp = (32'(cfg_data_i) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_data_i);
    end
  end

  // Decode the register write
  always_comb begin
    free_d    = free_q;
    unknown_d = unknown_q;
    width_d   = width_q;
    height_d  = height_q;
    restart_o = 1'b0;
    if (wr_en) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FREE:    free_d    = cfg_data_i[PIX_W-1:0];
        CFG_UNKNOWN: unknown_d = cfg_data_i[PIX_W-1:0];
        CFG_WIDTH: begin
          width_d   = width_clamp;
          restart_o = 1'b1;
        end
        CFG_HEIGHT: begin
          height_d  = height_clamp;
          restart_o = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q    <= FREE_RST;
      unknown_q <= UNKNOWN_RST;
      width_q   <= WIDTH_RST;
      height_q  <= HEIGHT_RST;
    end else begin
      free_q    <= free_d;
      unknown_q <= unknown_d;
      width_q   <= width_d;
      height_q  <= height_d;
    end
  end

  assign free_o    = free_q;
  assign unknown_o = unknown_q;
  assign width_o   = width_q;
  assign height_o  = height_q;

endmodule

>>> rtl/fcd_ctrl.sv
// ----------------------------------------------------------------------------
// fcd_ctrl
// Input position counters and the input register. Decodes which cell each
// accepted item completes and holds the item until the judge stage takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcd_ctrl import fcd_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int WW         = $clog2(MAX_WIDTH + 1),
  parameter int HW         = $clog2(MAX_HEIGHT + 1),
  parameter int IW         = $clog2(MAX_WIDTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WW-1:0]    width_i,
  input  logic [HW-1:0]    height_i,
  input  logic             restart_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [PIX_W-1:0] pixel_i,
  input  logic             consume_i,
  output logic             rd_en_o,
  output logic [IW-1:0]    rd_addr_o,
  output logic             s1_vld_o,
  output cell_t            s1_cell_o,
  output logic [PIX_W-1:0] s1_pixel_o,
  output logic [IW-1:0]    s1_addr_o
);

  // Row counter runs up to height + 1 during the flush
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int XW = ((RW > WW) ? RW : WW) + 1;

  logic [IW-1:0]    col_q, col_d;
  logic [RW-1:0]    row_q, row_d;
  logic             s1_vld_q, s1_vld_d;
  cell_t            s1_cell_q;
  logic [PIX_W-1:0] s1_pixel_q;
  logic [IW-1:0]    s1_addr_q;

  logic [XW-1:0] col_x, row_x, w_x, h_x, cr_x, cc_x;
  logic          col_pos, frame_wrap, row_end, accept;
  cell_t         pos;

  assign in_stall_o = s1_vld_q & ~consume_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign rd_en_o    = accept;
  assign rd_addr_o  = col_q;

  // Decode the cell completed by the item at the current position
  always_comb begin
    col_x   = XW'(col_q);
    row_x   = XW'(row_q);
    w_x     = XW'(width_i);
    h_x     = XW'(height_i);
    col_pos = (col_x != '0);
    if (col_pos) begin
      pos.vld = (row_x >= XW'(1)) && (row_x <= h_x);
      cr_x    = row_x - XW'(1);
      cc_x    = col_x - XW'(1);
    end else begin
      pos.vld = (row_x >= XW'(2)) && (row_x <= h_x + XW'(1));
      cr_x    = row_x - XW'(2);
      cc_x    = w_x - XW'(1);
    end
    pos.row    = COORD_W'(cr_x);
    pos.col    = COORD_W'(cc_x);
    pos.has_up = (cr_x != '0);
    pos.has_dn = (cr_x + XW'(1)) < h_x;
    pos.has_lf = (cc_x != '0);
    pos.has_rt = (cc_x + XW'(1)) < w_x;
    pos.last   = pos.vld && (cr_x == h_x - XW'(1)) && (cc_x == w_x - XW'(1));
    frame_wrap = pos.last || ((row_x >= h_x + XW'(1)) && !col_pos);
    row_end    = (col_x + XW'(1)) >= w_x;
  end

  // Advance the raster position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (frame_wrap) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end else begin
        col_d = col_q + IW'(1);
      end
    end
  end

  // Hold an item until the judge stage takes it
  always_comb begin
    s1_vld_d = s1_vld_q;
    if (accept) begin
      s1_vld_d = 1'b1;
    end else if (consume_i) begin
      s1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      s1_vld_q <= s1_vld_d;
    end
  end

  // Load the item payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cell_q  <= pos;
      s1_pixel_q <= pixel_i;
      s1_addr_q  <= col_q;
    end
  end

  assign s1_vld_o   = s1_vld_q;
  assign s1_cell_o  = s1_cell_q;
  assign s1_pixel_o = s1_pixel_q;
  assign s1_addr_o  = s1_addr_q;

endmodule

>>> rtl/fcd_line_buf.sv
// ----------------------------------------------------------------------------
// fcd_line_buf
// Upper and centre line stores in one memory word per column. Registered
// read on accept; a write to the same column in the same cycle is forwarded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcd_line_buf import fcd_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int IW        = $clog2(MAX_WIDTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IW-1:0]    rd_addr_i,
  input  logic             wr_en_i,
  input  logic [IW-1:0]    wr_addr_i,
  input  line_word_t       wr_data_i,
  output logic [PIX_W-1:0] upper_o,
  output logic [PIX_W-1:0] centre_o
);

  line_word_t mem [MAX_WIDTH];
  line_word_t rd_q;
  line_word_t fwd_data_q;
  logic       fwd_q;
  line_word_t rd_word;

  // Write the retiring column, read the arriving one
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // Flag a read that collided with a write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_word  = fwd_q ? fwd_data_q : rd_q;
  assign upper_o  = rd_word.upper;
  assign centre_o = rd_word.centre;

endmodule

>>> rtl/fcd_judge.sv
// ----------------------------------------------------------------------------
// fcd_judge
// Centre-row window and the lower/upper delays; judges the centre cell
// against its upper, lower, left and right neighbours and loads the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcd_judge import fcd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [PIX_W-1:0]   free_i,
  input  logic [PIX_W-1:0]   unknown_i,
  input  logic               s1_vld_i,
  input  cell_t              s1_cell_i,
  input  logic [PIX_W-1:0]   s1_pixel_i,
  input  logic [PIX_W-1:0]   upper_i,
  input  logic [PIX_W-1:0]   centre_i,
  output logic               consume_o,
  output line_word_t         wr_data_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COORD_W-1:0] cell_row_o,
  output logic [COORD_W-1:0] cell_col_o,
  output logic               is_frontier_o,
  output logic               last_of_frame_o
);

  logic [PIX_W-1:0] win1_q, win2_q;
  logic [PIX_W-1:0] lower_q, updly_q;
  logic             out_vld_q, out_vld_d;
  logic [COORD_W-1:0] row_q, col_q;
  logic             front_q, last_q;
  logic             out_free, load, unk, front;

  // Take a held item that completes no cell, or one whose cell the result register can hold
  assign out_free  = ~out_vld_q | ~out_stall_i;
  assign consume_o = s1_vld_i & (~s1_cell_i.vld | out_free);
  assign load      = consume_o & s1_cell_i.vld;

  // Retire the column into the line stores
  assign wr_data_o.upper  = centre_i;
  assign wr_data_o.centre = s1_pixel_i;

  // Judge the centre cell; window after shift is win1, win2, centre_i
  always_comb begin
    unk   = (s1_cell_i.has_up && (updly_q  == unknown_i)) ||
            (s1_cell_i.has_dn && (lower_q  == unknown_i)) ||
            (s1_cell_i.has_lf && (win1_q   == unknown_i)) ||
            (s1_cell_i.has_rt && (centre_i == unknown_i));
    front = (win2_q == free_i) && unk;
  end

  // Shift the window and delays on every taken item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win1_q  <= '0;
      win2_q  <= '0;
      lower_q <= '0;
      updly_q <= '0;
    end else if (consume_o) begin
      win1_q  <= win2_q;
      win2_q  <= centre_i;
      lower_q <= s1_pixel_i;
      updly_q <= upper_i;
    end
  end

  // Hold a result until taken
  always_comb begin
    if (load) begin
      out_vld_d = 1'b1;
    end else if (out_stall_i) begin
      out_vld_d = out_vld_q;
    end else begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      row_q   <= s1_cell_i.row;
      col_q   <= s1_cell_i.col;
      front_q <= front;
      last_q  <= s1_cell_i.last;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign cell_row_o      = row_q;
  assign cell_col_o      = col_q;
  assign is_frontier_o   = front_q;
  assign last_of_frame_o = last_q;

endmodule

>>> rtl/frontier_cell_detector_top.sv
// ----------------------------------------------------------------------------
// frontier_cell_detector_top
// Path: the item completing a cell passes the input register, then the result
//   register; a cell is completed image_width+1 items after its pixel.
// Throughput: one item per clock unless stalled; single-port-per-side line store.
// Reset: counters, window, delays, valid flags and configuration to defaults;
//   payload registers and line stores keep their contents, with no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frontier_cell_detector_top import fcd_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // pixel stream; kind is carried for the source, position alone decides
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  kind_i,
  input  logic [PIX_W-1:0]      pixel_i,
  // judged cells
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_W-1:0]    cell_row_o,
  output logic [COORD_W-1:0]    cell_col_o,
  output logic                  is_frontier_o,
  output logic                  last_of_frame_o
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int IW = $clog2(MAX_WIDTH);

  logic [PIX_W-1:0] free_val, unknown_val;
  logic [WW-1:0]    width;
  logic [HW-1:0]    height;
  logic             restart;
  logic             rd_en, consume, s1_vld;
  logic [IW-1:0]    rd_addr, s1_addr;
  cell_t            s1_cell;
  logic [PIX_W-1:0] s1_pixel, upper, centre;
  line_word_t       wr_data;

  fcd_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .WW        (WW),
    .HW        (HW)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .free_o     (free_val),
    .unknown_o  (unknown_val),
    .width_o    (width),
    .height_o   (height),
    .restart_o  (restart)
  );

  fcd_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .WW        (WW),
    .HW        (HW),
    .IW        (IW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .width_i   (width),
    .height_i  (height),
    .restart_i (restart),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .pixel_i   (pixel_i),
    .consume_i (consume),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .s1_vld_o  (s1_vld),
    .s1_cell_o (s1_cell),
    .s1_pixel_o(s1_pixel),
    .s1_addr_o (s1_addr)
  );

  fcd_line_buf #(
    .MAX_WIDTH(MAX_WIDTH),
    .IW       (IW)
  ) u_line_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .wr_en_i  (consume),
    .wr_addr_i(s1_addr),
    .wr_data_i(wr_data),
    .upper_o  (upper),
    .centre_o (centre)
  );

  fcd_judge u_judge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .free_i         (free_val),
    .unknown_i      (unknown_val),
    .s1_vld_i       (s1_vld),
    .s1_cell_i      (s1_cell),
    .s1_pixel_i     (s1_pixel),
    .upper_i        (upper),
    .centre_i       (centre),
    .consume_o      (consume),
    .wr_data_o      (wr_data),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .cell_row_o     (cell_row_o),
    .cell_col_o     (cell_col_o),
    .is_frontier_o  (is_frontier_o),
    .last_of_frame_o(last_of_frame_o)
  );

endmodule

>>> rtl/fcd_checker.sv
// ----------------------------------------------------------------------------
// fcd_checker
// Port-level checks on the frontier cell detector: result hold under stall,
// input stall only behind a stalled result, and result timing after accept.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcd_checker import fcd_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [COORD_W-1:0] cell_row_o,
  input logic [COORD_W-1:0] cell_col_o,
  input logic               is_frontier_o,
  input logic               last_of_frame_o
);

  // Hold a stalled result transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cell_row_o) &&
      $stable(cell_col_o) && $stable(is_frontier_o) && $stable(last_of_frame_o))
    else $error("stalled result changed");

  // Stall the input only behind a waiting, stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // Show a fresh result only behind an accepted item, through the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without an item accepted two cycles earlier");

endmodule

bind frontier_cell_detector_top fcd_checker u_fcd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .cell_row_o     (cell_row_o),
  .cell_col_o     (cell_col_o),
  .is_frontier_o  (is_frontier_o),
  .last_of_frame_o(last_of_frame_o)
);
